### rtl/iee_pkg.sv
`default_nettype none
package iee_pkg;

  localparam int OperatorDepth = 16;
  localparam int ValueDepth    = 16;
  localparam int FractionBits  = 16;
  localparam int ValueWidth    = 48;
  localparam int OpIdxW        = $clog2(OperatorDepth);
  localparam int ValIdxW       = $clog2(ValueDepth);
  localparam int OpCntW        = $clog2(OperatorDepth + 1);
  localparam int ValCntW       = $clog2(ValueDepth + 1);

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharMul    = 8'h2A;
  localparam logic [7:0] CharDiv    = 8'h2F;
  localparam logic [7:0] CharAdd    = 8'h2B;
  localparam logic [7:0] CharSub    = 8'h2D;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LPAREN = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_DIV    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_DIV_ZERO = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_PAREN    = 3'd3,
    ERR_OPERAND  = 3'd4,
    ERR_SATURATE = 3'd5
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOP,
    ST_POP_OP,
    ST_RD_A,
    ST_WAIT_A,
    ST_EXEC,
    ST_WAIT_ALU,
    ST_WB,
    ST_PUSH_OP,
    ST_FLUSH,
    ST_FINAL,
    ST_FINAL_RD,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {A_IDLE, A_MUL0, A_MUL1, A_MUL2, A_DIV, A_FIN} astate_t;

  typedef struct packed {
    logic        in_ready;
    logic        cap_char;
    logic        push_val;
    logic        push_op;
    op_t         push_code;
    logic        pop_op;
    logic        rd_b;
    logic        rd_a;
    logic        start_alu;
    logic        wb;
    logic        set_err;
    err_t        err;
    logic        load_out;
    logic        clear;
  } ctrl_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    op_t         op_top;
    logic        op_empty;
    logic        op_full;
    logic        val_full;
    logic        val_lt2;
    logic        alu_done;
    logic        out_busy;
  } stat_t;

endpackage
`default_nettype wire

### rtl/iee_alu.sv
`default_nettype none
module iee_alu
  import iee_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  op_t         op,
  input  value_t      a,
  input  value_t      b,
  output logic        done,
  output value_t      result,
  output err_t        err
);

  localparam int ProdW = 2 * ValueWidth;
  localparam int NumW  = ValueWidth + FractionBits;
  localparam int CntW  = $clog2(NumW + 1);
  localparam logic [ValueWidth:0] MagMax = {2'b00, {(ValueWidth-1){1'b1}}};

  astate_t                state_r, state_nxt;
  logic                   neg_r;
  logic [ValueWidth-1:0]  ua_r, ub_r;
  logic [ProdW-1:0]       acc_r;
  logic [ProdW-1:0]       pp_r;
  logic [NumW-1:0]        num_r;
  logic [ValueWidth:0]    rem_r;
  logic [ValueWidth:0]    q_r;
  logic                   over_r;
  logic [CntW-1:0]        cnt_r;
  logic                   done_r;
  value_t                 res_r;
  err_t                   err_r;

  logic [ValueWidth-1:0]  ua_c, ub_c;
  logic [ValueWidth:0]    rem_sh, rem_sub;
  logic                   ge;
  logic [ProdW-1:0]       prod_sh;
  logic [ProdW-FractionBits-1:0] hi_part;
  logic [ValueWidth:0]    lim;
  logic signed [ValueWidth:0] sum_w;
  logic                   done_nxt;
  logic [ValueWidth-1:0]  mul_ll, mul_hl, mul_lh, mul_hh;

  assign ua_c = a[ValueWidth-1] ? ValueWidth'(-a) : a;
  assign ub_c = b[ValueWidth-1] ? ValueWidth'(-b) : b;
  assign rem_sh  = {rem_r[ValueWidth-1:0], num_r[NumW-1]};
  assign ge      = rem_sh >= {1'b0, ub_r};
  assign rem_sub = rem_sh - {1'b0, ub_r};
  assign prod_sh = acc_r >> FractionBits;
  assign hi_part = prod_sh[ProdW-FractionBits-1:0];
  assign lim     = neg_r ? MagMax + 1'b1 : MagMax;
  assign sum_w   = (op == OP_SUB) ? {a[ValueWidth-1], a} - {b[ValueWidth-1], b}
                                  : {a[ValueWidth-1], a} + {b[ValueWidth-1], b};

  assign mul_ll = ValueWidth'(ua_r[23:0])  * ValueWidth'(ub_r[23:0]);
  assign mul_hl = ValueWidth'(ua_r[47:24]) * ValueWidth'(ub_r[23:0]);
  assign mul_lh = ValueWidth'(ua_r[23:0])  * ValueWidth'(ub_r[47:24]);
  assign mul_hh = ValueWidth'(ua_r[47:24]) * ValueWidth'(ub_r[47:24]);

  assign done_nxt = (state_r == A_FIN) ||
                    ((state_r == A_IDLE) && start &&
                     ((op == OP_ADD) || (op == OP_SUB) || ((op == OP_DIV) && (b == '0))));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (start && (op == OP_MUL)) state_nxt = A_MUL0;
        else if (start && (op == OP_DIV) && (b != '0)) state_nxt = A_DIV;
      end
      A_MUL0: state_nxt = A_MUL1;
      A_MUL1: state_nxt = A_MUL2;
      A_MUL2: state_nxt = A_FIN;
      A_DIV:  if (cnt_r == CntW'(1)) state_nxt = A_FIN;
      A_FIN:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Multiply forms four 24x24 partial products in states A_MUL0, A_MUL1 and A_MUL2.
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (start) begin
          neg_r  <= a[ValueWidth-1] ^ b[ValueWidth-1];
          ua_r   <= ua_c;
          ub_r   <= ub_c;
          acc_r  <= '0;
          num_r  <= NumW'({ua_c, {FractionBits{1'b0}}});
          rem_r  <= '0;
          q_r    <= '0;
          over_r <= 1'b0;
          cnt_r  <= CntW'(NumW);
          if (op == OP_ADD || op == OP_SUB) begin
            if (sum_w[ValueWidth] != sum_w[ValueWidth-1]) begin
              res_r <= sum_w[ValueWidth] ? {1'b1, {(ValueWidth-1){1'b0}}}
                                         : {1'b0, {(ValueWidth-1){1'b1}}};
              err_r <= ERR_SATURATE;
            end else begin
              res_r <= sum_w[ValueWidth-1:0];
              err_r <= ERR_OK;
            end
          end else if (op == OP_DIV && b == '0) begin
            res_r <= '0;
            err_r <= ERR_DIV_ZERO;
          end else begin
            err_r <= ERR_OK;
          end
        end
      end
      A_MUL0: begin
        pp_r  <= ProdW'(mul_ll);
      end
      A_MUL1: begin
        acc_r <= pp_r + (ProdW'(mul_hl) << 24);
        pp_r  <= ProdW'(mul_lh) << 24;
      end
      A_MUL2: begin
        acc_r <= acc_r + pp_r + (ProdW'(mul_hh) << 48);
        q_r   <= '0;
        over_r <= 1'b1;
      end
      A_DIV: begin
        rem_r <= ge ? rem_sub : rem_sh;
        num_r <= {num_r[NumW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (!over_r) begin
          if (q_r[ValueWidth] != 1'b0) over_r <= 1'b1;
          else q_r <= {q_r[ValueWidth-1:0], ge};
        end
      end
      A_FIN: begin
        if (op == OP_MUL) begin
          if ((hi_part >> ValueWidth) != '0 ||
              {1'b0, hi_part[ValueWidth-1:0]} > lim) begin
            res_r <= neg_r ? {1'b1, {(ValueWidth-1){1'b0}}}
                           : {1'b0, {(ValueWidth-1){1'b1}}};
            err_r <= ERR_SATURATE;
          end else begin
            res_r <= neg_r ? ValueWidth'(-hi_part[ValueWidth-1:0])
                           : hi_part[ValueWidth-1:0];
          end
        end else begin
          if (over_r || q_r > lim) begin
            res_r <= neg_r ? {1'b1, {(ValueWidth-1){1'b0}}}
                           : {1'b0, {(ValueWidth-1){1'b1}}};
            err_r <= ERR_SATURATE;
          end else begin
            res_r <= neg_r ? ValueWidth'(-q_r) : q_r[ValueWidth-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign result = res_r;
  assign err    = err_r;

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_DIV) |-> (cnt_r != '0)) else $error("divider count underflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_FIN) |=> done_r) else $error("finish without done");

endmodule
`default_nettype wire

### rtl/iee_datapath.sv
`default_nettype none
module iee_datapath
  import iee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  ctrl_t            ctrl,
  output stat_t            stat,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_last,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata
);

  op_t                 op_mem [OperatorDepth];
  value_t              val_mem [ValueDepth];
  logic [OpCntW-1:0]   op_cnt_r;
  logic [ValCntW-1:0]  val_cnt_r;
  logic [7:0]          ch_r;
  logic                last_r;
  op_t                 cur_op_r;
  value_t              rd_data_r;
  value_t              b_r;
  err_t                sticky_r;
  logic                out_valid_r;
  value_t              out_val_r;
  err_t                out_err_r;

  logic                alu_done;
  value_t              alu_res;
  err_t                alu_err;
  logic [ValIdxW-1:0]  rd_idx;
  logic [OpCntW-1:0]   op_dec;
  logic [ValCntW-1:0]  val_dec1;

  assign op_dec   = op_cnt_r - 1'b1;
  assign val_dec1 = val_cnt_r - 1'b1;

  always_comb begin
    if (ctrl.rd_a) rd_idx = ValIdxW'(val_cnt_r - ValCntW'(2));
    else           rd_idx = val_dec1[ValIdxW-1:0];
  end

  iee_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.start_alu),
    .op     (cur_op_r),
    .a      (rd_data_r),
    .b      (b_r),
    .done   (alu_done),
    .result (alu_res),
    .err    (alu_err)
  );

  always_ff @(posedge clk) begin
    rd_data_r <= val_mem[rd_idx];
    if (ctrl.rd_b) b_r <= val_mem[rd_idx];
    if (ctrl.push_val) val_mem[val_cnt_r[ValIdxW-1:0]] <=
      value_t'({(ch_r - CharZero), {FractionBits{1'b0}}});
    if (ctrl.wb) val_mem[ValIdxW'(val_cnt_r - ValCntW'(2))] <= alu_res;
    if (ctrl.push_op) op_mem[op_cnt_r[OpIdxW-1:0]] <= ctrl.push_code;
    if (ctrl.pop_op) cur_op_r <= op_mem[op_dec[OpIdxW-1:0]];
    if (ctrl.cap_char) begin
      ch_r   <= in_char;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r    <= '0;
      val_cnt_r   <= '0;
      sticky_r    <= ERR_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.push_val) val_cnt_r <= val_cnt_r + 1'b1;
      if (ctrl.wb) val_cnt_r <= val_dec1;
      if (ctrl.push_op) op_cnt_r <= op_cnt_r + 1'b1;
      if (ctrl.pop_op) op_cnt_r <= op_dec;
      if (ctrl.set_err && sticky_r == ERR_OK) sticky_r <= ctrl.err;
      if (ctrl.wb && sticky_r == ERR_OK) sticky_r <= alu_err;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
        out_val_r   <= (val_cnt_r == '0) ? '0 : rd_data_r;
        out_err_r   <= (sticky_r != ERR_OK) ? sticky_r :
                       (val_cnt_r != ValCntW'(1)) ? ERR_OPERAND : ERR_OK;
      end
      if (ctrl.clear) begin
        op_cnt_r  <= '0;
        val_cnt_r <= '0;
        sticky_r  <= ERR_OK;
      end
    end
  end

  always_comb begin
    stat.ch        = ch_r;
    stat.last      = last_r;
    stat.op_top    = (op_cnt_r == '0) ? OP_NONE : op_mem[op_dec[OpIdxW-1:0]];
    stat.op_empty  = (op_cnt_r == '0);
    stat.op_full   = (op_cnt_r >= OpCntW'(OperatorDepth));
    stat.val_full  = (val_cnt_r >= ValCntW'(ValueDepth));
    stat.val_lt2   = (val_cnt_r < ValCntW'(2));
    stat.alu_done  = alu_done;
    stat.out_busy  = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_err_r, out_val_r};

  a_op_bound: assert property (@(posedge clk) disable iff (!rst_n)
    op_cnt_r <= OpCntW'(OperatorDepth)) else $error("operator stack overrun");
  a_val_bound: assert property (@(posedge clk) disable iff (!rst_n)
    val_cnt_r <= ValCntW'(ValueDepth)) else $error("value stack overrun");
  a_wb_two: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wb |-> val_cnt_r >= ValCntW'(2)) else $error("writeback without operands");

endmodule
`default_nettype wire

### rtl/iee_ctrl.sv
`default_nettype none
module iee_ctrl
  import iee_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  stat_t      stat,
  output ctrl_t      ctrl
);

  state_t state_r, state_nxt;
  logic   flushing_r, flushing_nxt;
  logic   is_digit, is_mul, is_add, is_rp, is_lp;
  logic   loop_go;
  op_t    popped_r;

  assign is_digit = (stat.ch >= CharZero) && (stat.ch <= CharNine);
  assign is_mul   = (stat.ch == CharMul) || (stat.ch == CharDiv);
  assign is_add   = (stat.ch == CharAdd) || (stat.ch == CharSub);
  assign is_rp    = (stat.ch == CharRParen);
  assign is_lp    = (stat.ch == CharLParen);

  always_comb begin
    loop_go = 1'b0;
    if (!stat.op_empty) begin
      if (is_mul) loop_go = (stat.op_top == OP_MUL) || (stat.op_top == OP_DIV);
      else        loop_go = (stat.op_top != OP_LPAREN);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    flushing_nxt = flushing_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        flushing_nxt = 1'b0;
        if (is_digit) state_nxt = ST_FLUSH;
        else if (is_lp) state_nxt = ST_PUSH_OP;
        else if (is_rp || is_mul || is_add) state_nxt = ST_LOOP;
        else state_nxt = ST_FLUSH;
      end
      ST_LOOP: begin
        if (loop_go) state_nxt = ST_POP_OP;
        else if (is_rp) state_nxt = ST_FLUSH;
        else state_nxt = ST_PUSH_OP;
      end
      ST_POP_OP: state_nxt = ST_RD_A;
      ST_RD_A: begin
        if (flushing_r && popped_r == OP_LPAREN) state_nxt = ST_FLUSH;
        else if (stat.val_lt2) state_nxt = flushing_r ? ST_FLUSH : ST_LOOP;
        else state_nxt = ST_WAIT_A;
      end
      ST_WAIT_A: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_WAIT_ALU;
      ST_WAIT_ALU: if (stat.alu_done) state_nxt = ST_WB;
      ST_WB: state_nxt = flushing_r ? ST_FLUSH : ST_LOOP;
      ST_PUSH_OP: state_nxt = ST_FLUSH;
      ST_FLUSH: begin
        if (!stat.last) state_nxt = ST_IDLE;
        else if (!stat.op_empty) begin
          flushing_nxt = 1'b1;
          state_nxt = ST_POP_OP;
        end else state_nxt = ST_FINAL;
      end
      ST_FINAL: state_nxt = ST_FINAL_RD;
      ST_FINAL_RD: if (!stat.out_busy) state_nxt = ST_OUT;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The stack top has already moved on in ST_RD_A, so the paren check there
  // uses the code captured while the operator was popped.
  always_ff @(posedge clk) begin
    if (state_r == ST_POP_OP) popped_r <= stat.op_top;
  end

  always_comb begin
    ctrl = '0;
    ctrl.push_code = OP_NONE;
    ctrl.err = ERR_OK;
    case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.cap_char = in_valid;
      end
      ST_DECODE: begin
        if (is_digit) begin
          if (stat.val_full) begin
            ctrl.set_err = 1'b1;
            ctrl.err = ERR_OVERFLOW;
          end else ctrl.push_val = 1'b1;
        end
      end
      ST_LOOP: begin
        if (!loop_go && is_rp) begin
          if (stat.op_empty) begin
            ctrl.set_err = 1'b1;
            ctrl.err = ERR_PAREN;
          end else ctrl.pop_op = 1'b1;
        end
      end
      ST_POP_OP: begin
        ctrl.pop_op = 1'b1;
        ctrl.rd_b = 1'b1;
      end
      ST_RD_A: begin
        ctrl.rd_a = 1'b1;
        if (flushing_r && popped_r == OP_LPAREN) begin
          ctrl.set_err = 1'b1;
          ctrl.err = ERR_PAREN;
        end else if (stat.val_lt2) begin
          ctrl.set_err = 1'b1;
          ctrl.err = ERR_OPERAND;
        end
      end
      ST_WAIT_A: ctrl.rd_a = 1'b1;
      ST_EXEC: ctrl.start_alu = 1'b1;
      ST_WB: ctrl.wb = 1'b1;
      ST_PUSH_OP: begin
        if (stat.op_full) begin
          ctrl.set_err = 1'b1;
          ctrl.err = ERR_OVERFLOW;
        end else begin
          ctrl.push_op = 1'b1;
          if (is_lp) ctrl.push_code = OP_LPAREN;
          else if (stat.ch == CharMul) ctrl.push_code = OP_MUL;
          else if (stat.ch == CharDiv) ctrl.push_code = OP_DIV;
          else if (stat.ch == CharAdd) ctrl.push_code = OP_ADD;
          else ctrl.push_code = OP_SUB;
        end
      end
      ST_FINAL: ;
      ST_FINAL_RD: ;
      ST_OUT: begin
        ctrl.load_out = 1'b1;
        ctrl.clear = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      flushing_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      flushing_r <= flushing_nxt;
    end
  end

  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push_op && ctrl.pop_op)) else $error("push and pop together");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> !stat.out_busy) else $error("result overwritten");
  a_exec_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (state_r == ST_WAIT_ALU)) else $error("exec sequencing");

endmodule
`default_nettype wire

### rtl/infix_expression_evaluator_unit.sv
`default_nettype none
// Infix expression evaluator. Characters arrive one item at a time on the
// in_ stream: tdata carries the ASCII code, tlast marks the final character.
// Digits are single-digit operands; + - * / and parentheses are handled by a
// shunting-yard operator stack whose popped operators are applied at once to
// a value stack of signed 48-bit fixed-point numbers with 16 fraction bits.
// Other characters are ignored.
// On the item flagged tlast the operator stack is flushed and one result item
// is sent on the out_ stream: the value in tdata[47:0] and the first error
// code in tdata[50:48].
// A digit or ignored character passes through ST_IDLE, ST_DECODE and ST_FLUSH
// before the next item is accepted. Each applied operator passes through
// ST_POP_OP, ST_RD_A, ST_WAIT_A, ST_EXEC, ST_WAIT_ALU and ST_WB; the ALU forms
// four 24x24 partial products for multiply and divides with a restoring divider
// that retires one quotient bit per cycle over 64 bits. A character that pops several operators applies each in turn.
// Reset clears both stack pointers and the error; the stack memories need no
// clearing. The result sits in an output register; the block goes on
// accepting characters of the next expression while it waits, and stalls only
// when a second result is ready before the first was taken.
module infix_expression_evaluator_unit
  import iee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_code
  input  wire logic        in_tlast,   // end_of_expr
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // value[47:0], error_code[50:48], zero fill
);

  ctrl_t ctrl;
  stat_t stat;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  iee_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign in_tready = ctrl.in_ready;

endmodule
`default_nettype wire
